>>> design/rtu_fgr_pkg.sv
`timescale 1ns / 1ps

package rtu_fgr_pkg;

	// command carried in the input tuser field
	typedef enum logic [1:0] {
		CMD_RX_BYTE = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	// frame event reported with each result
	typedef enum logic [1:0] {
		EVT_NONE       = 2'd0,
		EVT_ACCEPT     = 2'd1,
		EVT_OTHER_ADDR = 2'd2
	} event_t;

	// configuration register indexes
	localparam logic [1:0] REG_STATION_ADDRESS = 2'd0;
	localparam logic [1:0] REG_GAP_RELOAD      = 2'd1;
	localparam logic [1:0] REG_EXEMPT_FUNCTION = 2'd2;

	// configuration reset values
	localparam logic [7:0] STATION_ADDRESS_RST = 8'd1;
	localparam logic [6:0] GAP_RELOAD_RST      = 7'd3;
	localparam logic [7:0] EXEMPT_FUNCTION_RST = 8'd0;

	// silence counter: top bit marks active, low bits count down
	localparam logic [7:0] SIL_ACTIVE = 8'h80;

	// a frame must hold more than this many bytes to be looked at
	localparam int MIN_FRAME_GT = 7;

endpackage

>>> design/rtu_fgr_store.sv
`timescale 1ns / 1ps

module rtu_fgr_store #(
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/rtu_frame_gap_receiver.sv
`timescale 1ns / 1ps

// RTU frame receiver with a two-slot ping-pong frame buffer.
// Input beats (s_tvalid/s_tready) carry a command in s_tuser: a received
// byte, a silence timer tick, a read of the pending frame or a release of it.
// Each input beat gives exactly one output beat (m_tvalid/m_tready) with the
// read byte, the frame event, the arm-timeout flag and the pending flag.
// Each beat goes through one input register, then the state update and
// frame store read into the result register. Throughput is one beat per
// cycle while m_tready is high; the store has one write and one read port
// and each beat uses at most one of them.
// Configuration is written via cfg_wr_en/cfg_index/cfg_data; the user must
// do so only while no beat is in flight, which the block does not enforce;
// an index beyond the register list is ignored. Reset clears the byte count,
// silence counter, slot pointers, pipeline and registers to defaults; the frame
// store is not cleared, so there is no clearing pass and beats go in at once.
// When m_tready is low the result holds, the input register can still fill,
// and s_tready falls once both stages are full; no beat is lost.

module rtu_frame_gap_receiver #(
	parameter int SLOT_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command (rtu_fgr_pkg::cmd_t)
	input  logic [1:0]  s_tuser,
	// [7:0] rx_byte, [8] line_error, [14:9] read_index, [15] zero
	input  logic [15:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] read_data, [9:8] frame_event, [10] arm_timeout,
	// [11] frame_pending, [15:12] zero
	output logic [15:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	import rtu_fgr_pkg::*;

	localparam int DEPTH  = 2 * SLOT_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int POS_W  = $clog2(SLOT_BYTES);
	localparam int CNT_W  = $clog2(SLOT_BYTES + 1);

	// configuration registers
	logic [7:0] station_q;
	logic [6:0] gap_reload_q;
	logic [7:0] exempt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q    <= STATION_ADDRESS_RST;
			gap_reload_q <= GAP_RELOAD_RST;
			exempt_q     <= EXEMPT_FUNCTION_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STATION_ADDRESS: station_q    <= cfg_data;
				REG_GAP_RELOAD:      gap_reload_q <= cfg_data[6:0];
				REG_EXEMPT_FUNCTION: exempt_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic valid_s1, valid_s2;
	logic adv;
	logic fire;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	// input register
	cmd_t       cmd_s1;
	logic [7:0] rx_s1;
	logic       err_s1;
	logic [5:0] idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= cmd_t'(s_tuser);
			rx_s1  <= s_tdata[7:0];
			err_s1 <= s_tdata[8];
			idx_s1 <= s_tdata[14:9];
		end
	end

	// framing state
	logic [CNT_W-1:0] count_q;
	logic [7:0]       silence_q;
	logic             fill_q, drain_q;
	logic [7:0]       addr_byte_q, func_byte_q;

	logic [CNT_W-1:0] count_d;
	logic [7:0]       silence_d;
	logic             fill_d, drain_d;
	logic [POS_W-1:0] wr_pos;
	logic             wr_en;
	logic [8:0]       wr_full, rd_full;
	logic             rd_en;
	event_t           event_d;
	logic             arm_d;

	// write position wraps to zero on a full slot
	assign wr_pos  = (count_q >= CNT_W'(SLOT_BYTES)) ? '0 : count_q[POS_W-1:0];
	assign wr_full = (fill_q ? 9'(SLOT_BYTES) : 9'd0) + 9'(wr_pos);
	assign rd_full = (drain_q ? 9'(SLOT_BYTES) : 9'd0) + {3'b000, idx_s1};

	// next state and result for the beat in the input register
	always_comb begin
		count_d   = count_q;
		silence_d = silence_q;
		fill_d    = fill_q;
		drain_d   = drain_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		event_d   = EVT_NONE;
		arm_d     = 1'b0;
		case (cmd_s1)
			CMD_RX_BYTE: begin
				if (!err_s1) begin
					wr_en     = 1'b1;
					count_d   = CNT_W'(wr_pos) + CNT_W'(1);
					silence_d = SIL_ACTIVE | {1'b0, gap_reload_q};
				end
			end
			CMD_TICK: begin
				if (silence_q[7]) begin
					if (silence_q == SIL_ACTIVE) begin
						silence_d = 8'd0;
						count_d   = '0;
						if (count_q > CNT_W'(MIN_FRAME_GT)) begin
							if (addr_byte_q == station_q) begin
								event_d = EVT_ACCEPT;
								arm_d   = (func_byte_q != exempt_q);
								fill_d  = !fill_q;
							end else begin
								event_d = EVT_OTHER_ADDR;
							end
						end
					end else begin
						silence_d = silence_q - 8'd1;
					end
				end
			end
			CMD_READ: begin
				rd_en = (fill_q != drain_q) && ({3'b000, idx_s1} < 9'(SLOT_BYTES));
			end
			CMD_RELEASE: begin
				if (fill_q != drain_q) begin
					drain_d = !drain_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			silence_q <= 8'd0;
			fill_q    <= 1'b0;
			drain_q   <= 1'b0;
		end else if (fire) begin
			count_q   <= count_d;
			silence_q <= silence_d;
			fill_q    <= fill_d;
			drain_q   <= drain_d;
		end
	end

	// copies of the address and function bytes of the frame being filled
	always_ff @(posedge clk) begin
		if (fire && wr_en && wr_pos == POS_W'(0)) begin
			addr_byte_q <= rx_s1;
		end
		if (fire && wr_en && wr_pos == POS_W'(1)) begin
			func_byte_q <= rx_s1;
		end
	end

	// frame store
	logic [7:0] rd_data;

	rtu_fgr_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (fire && wr_en),
		.wr_addr (wr_full[ADDR_W-1:0]),
		.wr_data (rx_s1),
		.rd_en   (fire && rd_en),
		.rd_addr (rd_full[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// result register
	logic   rd_en_s2;
	event_t event_s2;
	logic   arm_s2;
	logic   pend_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_en_s2 <= rd_en;
			event_s2 <= event_d;
			arm_s2   <= arm_d;
			pend_s2  <= (fill_d != drain_d);
		end
	end

	// output beat
	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, pend_s2, arm_s2, event_s2, (rd_en_s2 ? rd_data : 8'd0)};

endmodule
